### hw/rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Types and codes shared by the sorted stack priority queue modules.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                       mode;
    logic signed [VALUE_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  removed_value;
    logic [STATUS_W-1:0]        status;
    logic [OCC_W-1:0]           occupancy;
  } out_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                       ins;
    logic                       rem;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctl_t;

endpackage

### hw/rtl/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell
// One storage slot of the sorted chain. Slot 0 holds the largest value.
// ----------------------------------------------------------------------------
module sspq_cell (
  input  logic                               clk,
  input  sspq_pkg::cell_ctl_t                ctl,
  input  logic                               occ,
  input  logic                               above_gt,
  input  logic signed [sspq_pkg::VALUE_W-1:0] above_entry,
  input  logic signed [sspq_pkg::VALUE_W-1:0] below_entry,
  output logic                               gt,
  output logic signed [sspq_pkg::VALUE_W-1:0] entry
);
  import sspq_pkg::*;

  logic signed [VALUE_W-1:0] entry_next;

  // Strictly greater: equal stored values stay below the new one.
  assign gt = occ && (entry > ctl.value);

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (!gt) begin
        // first slot not greater takes the new value, the rest shift down
        entry_next = above_gt ? ctl.value : above_entry;
      end
    end else if (ctl.rem) begin
      entry_next = below_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### hw/rtl/sorted_stack_priority_queue_core.sv
// Sorted max priority queue of up to DEPTH signed 32-bit values, built as a
// chain of cells with the largest value in cell 0. Every cell compares its
// value with the incoming one in parallel, so no search loop is needed: one
// transaction per cycle while in_stall is low, with the result in an output
// register in the cycle after acceptance. Remove on empty returns status 1,
// insert on full returns status 2; both leave the contents unchanged.
// ----------------------------------------------------------------------------
// sorted_stack_priority_queue_core
// Top level: cell chain, fill count and result register.
// ----------------------------------------------------------------------------
module sorted_stack_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sspq_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sspq_pkg::out_t out_data
);
  import sspq_pkg::*;

  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               accept;
  logic               full;
  logic               empty;
  cell_ctl_t          ctl;
  out_t               out_next;
  logic               out_valid_next;

  logic                      gt  [DEPTH];
  logic signed [VALUE_W-1:0] ent [DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == DEPTH_C);
  assign empty    = (count == '0);

  always_comb begin
    ctl.value = in_data.value;
    ctl.ins   = accept && (in_data.mode == MODE_INSERT) && !full;
    ctl.rem   = accept && (in_data.mode == MODE_REMOVE) && !empty;
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                      above_gt;
      logic signed [VALUE_W-1:0] above_entry;
      logic signed [VALUE_W-1:0] below_entry;

      if (i == 0) begin : g_top
        assign above_gt    = 1'b1;
        assign above_entry = in_data.value;
      end else begin : g_mid
        assign above_gt    = gt[i-1];
        assign above_entry = ent[i-1];
      end

      if (i == DEPTH - 1) begin : g_bot
        assign below_entry = ent[i];
      end else begin : g_up
        assign below_entry = ent[i+1];
      end

      sspq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occ         (COUNT_W'(i) < count),
        .above_gt    (above_gt),
        .above_entry (above_entry),
        .below_entry (below_entry),
        .gt          (gt[i]),
        .entry       (ent[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + 1'b1;
    end else if (ctl.rem) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    out_next       = out_data;
    if (accept) begin
      out_valid_next         = 1'b1;
      out_next.removed_value = '0;
      out_next.status        = ST_OK;
      out_next.occupancy     = OCC_W'(count_next);
      if (in_data.mode == MODE_INSERT) begin
        if (full) begin
          out_next.status = ST_FULL;
        end
      end else if (empty) begin
        out_next.status = ST_EMPTY;
      end else begin
        out_next.removed_value = ent[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("fill count above depth");

  a_sorted_top: assert property (@(posedge clk) disable iff (rst)
    (count >= COUNT_W'(2)) |-> (ent[0] >= ent[1]))
    else $error("top two entries out of order");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow count");

  a_remove_value: assert property (@(posedge clk) disable iff (rst)
    ctl.rem |=> (out_data.removed_value == $past(ent[0]) && out_data.status == ST_OK))
    else $error("remove returned wrong value");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

endmodule

### tb/sv/sorted_stack_priority_queue_core_test.sv
// ----------------------------------------------------------------------------
// sorted_stack_priority_queue_core_test
// Self-checking bench for the sorted max priority queue. A scoreboard keeps
// its own sorted copy of the store and predicts every result transaction.
// Directed corner cases come first, then random fill, drain and mixed phases.
// Random idle gaps are applied on both the request and the result side.
// ----------------------------------------------------------------------------
module sorted_stack_priority_queue_core_test;
  import sspq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_GAP      = 11;
  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 8;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  class sorted_queue_scoreboard;
    logic signed [VALUE_W-1:0] held[$];   // ascending, top of stack at back
    out_t                      pending[$];
    int unsigned               mismatches;

    function void note_request(in_t req);
      out_t res;
      int   pos;
      res        = '0;
      res.status = ST_OK;
      if (req.mode == MODE_INSERT) begin
        if (held.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // new value lands above every stored value <= it
          pos = held.size();
          while (pos > 0 && $signed(held[pos-1]) > $signed(req.value)) pos--;
          held.insert(pos, req.value);
        end
      end else if (held.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_value = held.pop_back();
      end
      res.occupancy = OCC_W'(held.size());
      pending.push_back(res);
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d status %0d occupancy %0d",
                   got.removed_value, got.status, got.occupancy);
        return;
      end
      want = pending.pop_front();
      if (got.removed_value !== want.removed_value || got.status !== want.status ||
          got.occupancy !== want.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("bad result: expected value %0d status %0d occupancy %0d, got %0d %0d %0d",
                   want.removed_value, want.status, want.occupancy,
                   got.removed_value, got.status, got.occupancy);
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int   cycle_count = 0;
  int   send_calm   = 0;
  int   recv_calm   = 0;

  sorted_queue_scoreboard scb = new;

  sorted_stack_priority_queue_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // idle cycles before a transaction; occasional runs of back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic signed [VALUE_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return int'($urandom_range(0, 8)) - 4;   // lots of duplicates
      8:             return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
      default:       return $urandom_range(0, 1) ? VALUE_MAX - int'($urandom_range(0, 3))
                                                 : VALUE_MIN + int'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic drive_item(input logic mode, input logic signed [VALUE_W-1:0] value);
    in_t item;
    int  gap;
    item.mode  = mode;
    item.value = value;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) scb.note_request(in_data);
      if (out_valid && !out_stall) scb.check_response(out_data);
    end
  end

  initial begin : result_sink
    int gap;
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int phase_left;
    int insert_pct;
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // remove while empty, extremes, duplicates, then fill up and overflow
    drive_item(MODE_REMOVE, 32'sd0);
    drive_item(MODE_INSERT, VALUE_MAX);
    drive_item(MODE_INSERT, VALUE_MIN);
    drive_item(MODE_INSERT, 32'sd0);
    drive_item(MODE_INSERT, -32'sd1);
    drive_item(MODE_INSERT, 32'sd1);
    drive_item(MODE_INSERT, 32'sd0);
    drive_item(MODE_INSERT, VALUE_MIN);
    drive_item(MODE_INSERT, VALUE_MAX);
    drive_item(MODE_REMOVE, $urandom);
    drive_item(MODE_REMOVE, $urandom);
    repeat (10) drive_item(MODE_INSERT, draw_value());
    drive_item(MODE_INSERT, draw_value());

    // random phases biased toward filling, draining, or balanced traffic
    n          = 0;
    phase_left = 0;
    insert_pct = 50;
    while (n < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      drive_item(($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE,
                 draw_value());
      phase_left--;
      n++;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (scb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scb.mismatches == 0 && scb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
hw/rtl/sspq_pkg.sv
hw/rtl/sspq_cell.sv
hw/rtl/sorted_stack_priority_queue_core.sv
tb/sv/sorted_stack_priority_queue_core_test.sv
